FILE: hw/rtl/swlcd_pkg.sv
// Shared types, codes and helpers for the stopwatch LCD writer.
`timescale 1ns / 1ps
`default_nettype none
package swlcd_pkg;

    // Request kinds carried in the slave-side tuser
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_STOP  = 2'd1;
    localparam logic [1:0] REQ_START = 2'd2;
    localparam logic [1:0] REQ_RESET = 2'd3;

    // Register indexes
    localparam logic REG_DISPLAY_BASE = 1'b0;

    localparam logic [7:0] CMD_SET_ADDR = 8'h80;
    localparam logic [7:0] ASCII_ZERO   = 8'h30;
    localparam logic [7:0] ASCII_COLON  = 8'h3a;
    localparam logic [6:0] BASE_RESET   = 7'h59;

    // Digit limits
    localparam logic [3:0] DEC_MAX     = 4'd9;
    localparam logic [2:0] SECS_TENS_MAX = 3'd5;

    // Write sequence: seven address/char pairs, then the cursor restore
    localparam logic [3:0] LAST_STEP = 4'd14;

    // Snapshot queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [3:0] mins_tens;
        logic [3:0] mins_ones;
        logic [2:0] secs_tens;
        logic [3:0] secs_ones;
        logic [3:0] tenths;
        logic [6:0] cursor;
    } t_snap;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        return ASCII_ZERO + {4'b0000, d};
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/swlcd_fifo.sv
// Short snapshot queue between the request front end and the write sequencer.
`timescale 1ns / 1ps
`default_nettype none
module swlcd_fifo (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  swlcd_pkg::t_snap    i_push_data,
    input  wire                 i_pop,
    output swlcd_pkg::t_snap    o_head,
    output swlcd_pkg::t_qstat   o_stat
);

    swlcd_pkg::t_snap                  r_mem [swlcd_pkg::QDEPTH];
    logic [swlcd_pkg::QPTR_W-1:0]      r_wp;
    logic [swlcd_pkg::QPTR_W-1:0]      r_rp;
    logic [swlcd_pkg::QCNT_W-1:0]      r_cnt;
    logic                              w_push;
    logic                              w_pop;

    assign o_stat.full  = (r_cnt == swlcd_pkg::QCNT_W'(swlcd_pkg::QDEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign w_push       = i_push && !o_stat.full;
    assign w_pop        = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/swlcd_front.sv
// Request front end: run control, prescale and decimal time count.
`timescale 1ns / 1ps
`default_nettype none
module swlcd_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire  [1:0]          i_req_type,
    input  wire  [6:0]          i_cursor_addr,
    input  swlcd_pkg::t_qstat   i_qstat,
    output logic                o_push,
    output swlcd_pkg::t_snap    o_push_data
);

    logic       r_running;
    logic       r_half_tick;
    logic [3:0] r_tenths, n_tenths;
    logic [3:0] r_secs_ones, n_secs_ones;
    logic [2:0] r_secs_tens, n_secs_tens;
    logic [3:0] r_mins_ones, n_mins_ones;
    logic [3:0] r_mins_tens, n_mins_tens;
    logic       w_accept;
    logic       w_count;

    assign o_ready  = !i_qstat.full;
    assign w_accept = i_valid && o_ready;
    assign w_count  = w_accept && (i_req_type == swlcd_pkg::REQ_TICK)
                      && r_running && r_half_tick;

    // Ripple-carry decimal advance; a digit at or above its limit wraps
    always_comb begin
        n_tenths    = r_tenths;
        n_secs_ones = r_secs_ones;
        n_secs_tens = r_secs_tens;
        n_mins_ones = r_mins_ones;
        n_mins_tens = r_mins_tens;
        if (r_tenths >= swlcd_pkg::DEC_MAX) begin
            n_tenths = '0;
            if (r_secs_ones >= swlcd_pkg::DEC_MAX) begin
                n_secs_ones = '0;
                if (r_secs_tens >= swlcd_pkg::SECS_TENS_MAX) begin
                    n_secs_tens = '0;
                    if (r_mins_ones >= swlcd_pkg::DEC_MAX) begin
                        n_mins_ones = '0;
                        if (r_mins_tens >= swlcd_pkg::DEC_MAX) begin
                            n_mins_tens = '0;
                        end else begin
                            n_mins_tens = r_mins_tens + 1'b1;
                        end
                    end else begin
                        n_mins_ones = r_mins_ones + 1'b1;
                    end
                end else begin
                    n_secs_tens = r_secs_tens + 1'b1;
                end
            end else begin
                n_secs_ones = r_secs_ones + 1'b1;
            end
        end else begin
            n_tenths = r_tenths + 1'b1;
        end
    end

    assign o_push                = w_count;
    assign o_push_data.mins_tens = n_mins_tens;
    assign o_push_data.mins_ones = n_mins_ones;
    assign o_push_data.secs_tens = n_secs_tens;
    assign o_push_data.secs_ones = n_secs_ones;
    assign o_push_data.tenths    = n_tenths;
    assign o_push_data.cursor    = i_cursor_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running   <= 1'b1;
            r_half_tick <= 1'b0;
            r_tenths    <= '0;
            r_secs_ones <= '0;
            r_secs_tens <= '0;
            r_mins_ones <= '0;
            r_mins_tens <= '0;
        end else if (w_accept) begin
            unique case (i_req_type)
                swlcd_pkg::REQ_STOP: begin
                    r_running <= 1'b0;
                end
                swlcd_pkg::REQ_START: begin
                    r_running <= 1'b1;
                end
                swlcd_pkg::REQ_RESET: begin
                    r_running   <= 1'b1;
                    r_half_tick <= 1'b0;
                    r_tenths    <= '0;
                    r_secs_ones <= '0;
                    r_secs_tens <= '0;
                    r_mins_ones <= '0;
                    r_mins_tens <= '0;
                end
                default: begin
                    if (r_running) begin
                        r_half_tick <= !r_half_tick;
                        if (r_half_tick) begin
                            r_tenths    <= n_tenths;
                            r_secs_ones <= n_secs_ones;
                            r_secs_tens <= n_secs_tens;
                            r_mins_ones <= n_mins_ones;
                            r_mins_tens <= n_mins_tens;
                        end
                    end
                end
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/swlcd_back.sv
// Write sequencer: turns one time snapshot into fifteen LCD bus writes.
`timescale 1ns / 1ps
`default_nettype none
module swlcd_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire  [6:0]          i_display_base,
    input  swlcd_pkg::t_snap    i_head,
    input  swlcd_pkg::t_qstat   i_qstat,
    output logic                o_pop,
    output logic                o_valid,
    input  wire                 i_ready,
    output logic                o_is_data,
    output logic [7:0]          o_bus_byte,
    output logic                o_last
);

    logic       r_valid;
    logic       r_is_data;
    logic [7:0] r_bus_byte;
    logic       r_last;
    logic [3:0] r_step;
    logic       w_advance;
    logic       w_load;
    logic [2:0] w_pos;
    logic [6:0] w_addr;
    logic [7:0] w_char;
    logic [7:0] n_bus_byte;
    logic       n_is_data;
    logic       n_last;

    assign w_advance = !r_valid || i_ready;
    assign w_load    = w_advance && !i_qstat.empty;
    assign o_pop     = w_load && (r_step == swlcd_pkg::LAST_STEP);
    assign w_pos     = r_step[3:1];
    assign w_addr    = i_display_base + {4'b0000, w_pos};

    always_comb begin
        case (w_pos)
            3'd0:    w_char = swlcd_pkg::digit_char(i_head.mins_tens);
            3'd1:    w_char = swlcd_pkg::digit_char(i_head.mins_ones);
            3'd3:    w_char = swlcd_pkg::digit_char({1'b0, i_head.secs_tens});
            3'd4:    w_char = swlcd_pkg::digit_char(i_head.secs_ones);
            3'd6:    w_char = swlcd_pkg::digit_char(i_head.tenths);
            default: w_char = swlcd_pkg::ASCII_COLON;
        endcase
    end

    always_comb begin
        if (r_step == swlcd_pkg::LAST_STEP) begin
            n_is_data  = 1'b0;
            n_bus_byte = swlcd_pkg::CMD_SET_ADDR | {1'b0, i_head.cursor};
            n_last     = 1'b1;
        end else if (r_step[0]) begin
            n_is_data  = 1'b1;
            n_bus_byte = w_char;
            n_last     = 1'b0;
        end else begin
            n_is_data  = 1'b0;
            n_bus_byte = swlcd_pkg::CMD_SET_ADDR | {1'b0, w_addr};
            n_last     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_is_data  <= n_is_data;
            r_bus_byte <= n_bus_byte;
            r_last     <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= '0;
        end else if (w_advance) begin
            r_valid <= !i_qstat.empty;
            if (w_load) begin
                r_step <= (r_step == swlcd_pkg::LAST_STEP) ? 4'd0 : r_step + 1'b1;
            end
        end
    end

    assign o_valid    = r_valid;
    assign o_is_data  = r_is_data;
    assign o_bus_byte = r_bus_byte;
    assign o_last     = r_last;

endmodule
`default_nettype wire

FILE: hw/rtl/stopwatch_lcd_display_writer_top.sv
// Stopwatch LCD writer: the base register, front end, snapshot queue and write sequencer.
// Flow: a counting tick's snapshot enters the queue as the tick transfers; the sequencer
// registers its writes, one write a cycle while the output side takes them, 15 in all.
// Throughput: one request a cycle; a counting tick occupies the sequencer for 15 writes,
// the two-entry snapshot queue absorbs bursts, and the input stalls while it is full.
// Reset (synchronous, active low): running set, count and prescale cleared, base = 0x59.
`timescale 1ns / 1ps
`default_nettype none
module stopwatch_lcd_display_writer_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // [6:0] cursor_addr, [7] zero
    input  wire  [1:0]  s_axis_tuser,   // [1:0] req_type
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] bus_byte
    output logic        m_axis_tuser,   // [0] is_data
    output logic        m_axis_tlast,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [6:0]         r_base;
    logic               w_cfg_wr;
    logic               w_push;
    logic               w_pop;
    swlcd_pkg::t_snap   w_push_data;
    swlcd_pkg::t_snap   w_head;
    swlcd_pkg::t_qstat  w_qstat;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite
                      && (paddr[2] == swlcd_pkg::REG_DISPLAY_BASE);
    assign prdata   = (paddr[2] == swlcd_pkg::REG_DISPLAY_BASE) ? {25'd0, r_base} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= swlcd_pkg::BASE_RESET;
        end else if (w_cfg_wr) begin
            r_base <= pwdata[6:0];
        end
    end

    swlcd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_req_type    (s_axis_tuser),
        .i_cursor_addr (s_axis_tdata[6:0]),
        .i_qstat       (w_qstat),
        .o_push        (w_push),
        .o_push_data   (w_push_data)
    );

    swlcd_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_pop       (w_pop),
        .o_head      (w_head),
        .o_stat      (w_qstat)
    );

    swlcd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_display_base (r_base),
        .i_head         (w_head),
        .i_qstat        (w_qstat),
        .o_pop          (w_pop),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_is_data      (m_axis_tuser),
        .o_bus_byte     (m_axis_tdata),
        .o_last         (m_axis_tlast)
    );

endmodule
`default_nettype wire

FILE: tb/tb_stopwatch_lcd_display_writer_top.sv
// Testbench for the stopwatch LCD writer: request stream in, LCD bus writes out, base register.
`timescale 1ns / 1ps
`default_nettype none
module tb_stopwatch_lcd_display_writer_top;

    localparam int SETTLE_CYCLES  = 20;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int RANDOM_ROUNDS  = 2;
    localparam int ROUND_ITEMS    = 40;
    // 00:06:0 on the display: carries the tenths into the seconds several times
    localparam int ROLLOVER_TENTHS = 60;

    typedef struct packed {
        logic       is_data;
        logic [7:0] bus_byte;
        logic       last;
    } t_lcd_write;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [6:0] cursor_addr, [7] zero
    logic [1:0]  s_axis_tuser;   // [1:0] req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // [7:0] bus_byte
    logic        m_axis_tuser;   // [0] is_data
    logic        m_axis_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    stopwatch_lcd_display_writer_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #1 i_clk = ~i_clk;

    // Stopwatch state as the block should hold it
    logic       sw_running   = 1'b1;
    logic       sw_half_tick = 1'b0;
    logic [3:0] sw_tenths    = '0;
    logic [3:0] sw_secs_ones = '0;
    logic [2:0] sw_secs_tens = '0;
    logic [3:0] sw_mins_ones = '0;
    logic [3:0] sw_mins_tens = '0;
    logic [6:0] sw_base      = swlcd_pkg::BASE_RESET;

    t_lcd_write lcd_writes_q[$];

    int  mismatches     = 0;
    int  writes_checked = 0;
    int  reqs_sent      = 0;
    int  ticks_sent     = 0;
    int  input_stalls   = 0;
    int  base_settings  = 1;
    bit  steady_flow    = 1'b0;
    int  rx_hold_reqs   = 0;
    int  rx_hold_seen   = 0;
    int  rx_hold_left   = 0;

    function automatic void step_tenths();
        if (sw_tenths >= swlcd_pkg::DEC_MAX) begin
            sw_tenths = '0;
            if (sw_secs_ones >= swlcd_pkg::DEC_MAX) begin
                sw_secs_ones = '0;
                if (sw_secs_tens >= swlcd_pkg::SECS_TENS_MAX) begin
                    sw_secs_tens = '0;
                    if (sw_mins_ones >= swlcd_pkg::DEC_MAX) begin
                        sw_mins_ones = '0;
                        sw_mins_tens = (sw_mins_tens >= swlcd_pkg::DEC_MAX)
                                       ? 4'd0 : sw_mins_tens + 4'd1;
                    end else begin
                        sw_mins_ones = sw_mins_ones + 4'd1;
                    end
                end else begin
                    sw_secs_tens = sw_secs_tens + 3'd1;
                end
            end else begin
                sw_secs_ones = sw_secs_ones + 4'd1;
            end
        end else begin
            sw_tenths = sw_tenths + 4'd1;
        end
    endfunction

    function automatic void predict_request(input logic [1:0] req, input logic [6:0] cursor);
        logic [7:0] chars[7];
        logic [6:0] addr;
        case (req)
            swlcd_pkg::REQ_STOP: sw_running = 1'b0;
            swlcd_pkg::REQ_START: sw_running = 1'b1;
            swlcd_pkg::REQ_RESET: begin
                sw_tenths    = '0;
                sw_secs_ones = '0;
                sw_secs_tens = '0;
                sw_mins_ones = '0;
                sw_mins_tens = '0;
                sw_half_tick = 1'b0;
                sw_running   = 1'b1;
            end
            default: begin
                if (sw_running) begin
                    if (!sw_half_tick) begin
                        sw_half_tick = 1'b1;
                    end else begin
                        sw_half_tick = 1'b0;
                        step_tenths();
                        chars[0] = swlcd_pkg::ASCII_ZERO + {4'd0, sw_mins_tens};
                        chars[1] = swlcd_pkg::ASCII_ZERO + {4'd0, sw_mins_ones};
                        chars[2] = swlcd_pkg::ASCII_COLON;
                        chars[3] = swlcd_pkg::ASCII_ZERO + {5'd0, sw_secs_tens};
                        chars[4] = swlcd_pkg::ASCII_ZERO + {4'd0, sw_secs_ones};
                        chars[5] = swlcd_pkg::ASCII_COLON;
                        chars[6] = swlcd_pkg::ASCII_ZERO + {4'd0, sw_tenths};
                        for (int k = 0; k < 7; k++) begin
                            addr = sw_base + 7'(k);
                            lcd_writes_q.push_back(
                                '{1'b0, swlcd_pkg::CMD_SET_ADDR | {1'b0, addr}, 1'b0});
                            lcd_writes_q.push_back('{1'b1, chars[k], 1'b0});
                        end
                        lcd_writes_q.push_back(
                            '{1'b0, swlcd_pkg::CMD_SET_ADDR | {1'b0, cursor}, 1'b1});
                    end
                end
            end
        endcase
    endfunction

    // Predict on each request transfer, check each LCD write transfer
    always @(posedge i_clk) begin
        t_lcd_write exp_w;
        if (i_rst_n) begin
            if (s_axis_tvalid && !s_axis_tready)
                input_stalls++;
            if (s_axis_tvalid && s_axis_tready)
                predict_request(s_axis_tuser, s_axis_tdata[6:0]);
            if (m_axis_tvalid && m_axis_tready) begin
                writes_checked++;
                if (lcd_writes_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected write: expected none, actual data=%0b byte=%02h last=%0b",
                             $time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
                end else begin
                    exp_w = lcd_writes_q.pop_front();
                    if (m_axis_tuser !== exp_w.is_data) begin
                        mismatches++;
                        $display("%0t: is_data mismatch: expected %0b, actual %0b",
                                 $time, exp_w.is_data, m_axis_tuser);
                    end
                    if (m_axis_tdata !== exp_w.bus_byte) begin
                        mismatches++;
                        $display("%0t: bus_byte mismatch: expected %02h, actual %02h",
                                 $time, exp_w.bus_byte, m_axis_tdata);
                    end
                    if (m_axis_tlast !== exp_w.last) begin
                        mismatches++;
                        $display("%0t: last mismatch: expected %0b, actual %0b",
                                 $time, exp_w.last, m_axis_tlast);
                    end
                end
            end
        end
    end

    // Output side: random stalls, a counted hold-off on request, none in steady flow
    always @(negedge i_clk) begin
        if (rx_hold_reqs != rx_hold_seen) begin
            rx_hold_seen  <= rx_hold_reqs;
            rx_hold_left  <= RX_HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (rx_hold_left != 0) begin
            rx_hold_left  <= rx_hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= steady_flow || ($urandom_range(99) >= 9);
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer
    task automatic send_request(input logic [1:0] req, input logic [6:0] cursor);
        while (!steady_flow && $urandom_range(99) < 9) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {1'b0, cursor};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        reqs_sent++;
        if (req == swlcd_pkg::REQ_TICK)
            ticks_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_tick(input logic [6:0] cursor);
        send_request(swlcd_pkg::REQ_TICK, cursor);
    endtask

    // Drop valid, drain every expected write, then let the block go quiet
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (lcd_writes_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_base(input logic [6:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(swlcd_pkg::REG_DISPLAY_BASE) << 2;
        pwdata  <= {25'd0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        sw_base = value;
        base_settings++;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_base_readback();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= 3'(swlcd_pkg::REG_DISPLAY_BASE) << 2;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        if (prdata[6:0] !== sw_base) begin
            mismatches++;
            $display("%0t: display_base readback mismatch: expected %02h, actual %02h",
                     $time, sw_base, prdata[6:0]);
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_base(input logic [6:0] value);
        settle();
        write_base(value);
        check_base_readback();
    endtask

    // Every request kind, stop/start around a half tick, reset while stopped
    task automatic test_request_kinds();
        check_base_readback();
        send_tick(7'd0);
        send_tick(7'd127);
        send_request(swlcd_pkg::REQ_STOP, 7'd3);
        send_tick(7'd10);
        send_tick(7'd11);
        send_request(swlcd_pkg::REQ_START, 7'd127);
        send_tick(7'd0);
        send_tick(7'h55);
        send_request(swlcd_pkg::REQ_RESET, 7'd0);
        send_tick(7'd1);
        send_tick(7'd0);
        send_tick(7'h2a);
        send_request(swlcd_pkg::REQ_STOP, 7'd0);
        send_request(swlcd_pkg::REQ_START, 7'd0);
        send_tick(7'h7e);
        send_request(swlcd_pkg::REQ_STOP, 7'd127);
        send_request(swlcd_pkg::REQ_RESET, 7'd127);
        send_tick(7'h40);
        send_tick(7'h3f);
        send_request(swlcd_pkg::REQ_START, 7'd5);
        send_tick(7'h01);
        send_tick(7'h7f);
    endtask

    // Lowest, highest and past-range base; the last wraps the LCD address
    task automatic test_base_extremes();
        logic [6:0] bases[3] = '{7'd0, 7'd121, 7'd127};
        foreach (bases[b]) begin
            set_base(bases[b]);
            send_tick(7'h12);
            send_tick(7'h6d);
            send_tick(7'h00);
            send_tick(7'h7f);
        end
    endtask

    // Hold the output off while ticks keep coming so the input has to stall
    task automatic test_input_backpressure();
        set_base(7'h40);
        rx_hold_reqs++;
        for (int n = 0; n < 24; n++)
            send_tick(7'($urandom_range(127)));
    endtask

    // Unbroken run from zero through several tenths-to-seconds carries
    task automatic test_count_rollover();
        set_base(swlcd_pkg::BASE_RESET);
        steady_flow = 1'b1;
        send_request(swlcd_pkg::REQ_RESET, 7'($urandom_range(127)));
        for (int n = 0; n < 2 * ROLLOVER_TENTHS; n++)
            send_tick(7'($urandom_range(127)));
        settle();
        steady_flow = 1'b0;
    endtask

    // Mostly counting ticks with stops, starts and resets mixed in
    task automatic test_random_mix();
        int pick;
        logic [1:0] req;
        for (int r = 0; r < RANDOM_ROUNDS; r++) begin
            set_base(7'($urandom_range(121)));
            for (int n = 0; n < ROUND_ITEMS; n++) begin
                pick = $urandom_range(99);
                if (pick < 76)
                    req = swlcd_pkg::REQ_TICK;
                else if (pick < 85)
                    req = swlcd_pkg::REQ_STOP;
                else if (pick < 95)
                    req = swlcd_pkg::REQ_START;
                else
                    req = swlcd_pkg::REQ_RESET;
                send_request(req, 7'($urandom_range(127)));
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = swlcd_pkg::REQ_TICK;
        m_axis_tready = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_request_kinds();
        test_base_extremes();
        test_input_backpressure();
        test_count_rollover();
        test_random_mix();
        settle();

        $display("Sent %0d requests (%0d ticks) over %0d base settings; checked %0d LCD writes.",
                 reqs_sent, ticks_sent, base_settings, writes_checked);
        $display("Input held off for %0d cycles by output back-pressure; count carried into seconds.",
                 input_stalls);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #400000;
        $display("Timeout: %0d writes still expected", lcd_writes_q.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
`default_nettype wire
